// ===== hw/rtl/nsr_pkg.sv =====
// nsr_pkg: shared constants, types and helpers for the nmea sentence receiver
// used by nsr_step, nsr_out_reg and nmea_sentence_receiver_top; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package nsr_pkg;

    // default body size at which a frame is abandoned
    localparam int MAX_BODY_DEF = 128;

    // framing phases
    localparam logic [2:0] PH_HUNT  = 3'd0;
    localparam logic [2:0] PH_START = 3'd1;
    localparam logic [2:0] PH_BODY  = 3'd2;
    localparam logic [2:0] PH_CK1   = 3'd3;
    localparam logic [2:0] PH_CK2   = 3'd4;
    localparam logic [2:0] PH_CR    = 3'd5;
    localparam logic [2:0] PH_LF    = 3'd6;

    // framing characters
    localparam logic [7:0] CH_START = 8'h24;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    // result event codes
    localparam logic [1:0] EV_NONE  = 2'd0;
    localparam logic [1:0] EV_BYTE  = 2'd1;
    localparam logic [1:0] EV_DONE  = 2'd2;
    localparam logic [1:0] EV_ABORT = 2'd3;

    // one result item
    typedef struct packed {
        logic [6:0] sentence_length;
        logic [6:0] body_index;
        logic [7:0] body_byte;
        logic [1:0] event_res;
    } t_result;

    // nibble to uppercase ascii hex digit
    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        logic [7:0] r;
        if (nib < 4'd10) begin
            r = 8'h30 + {4'd0, nib};
        end else begin
            r = 8'h41 + {4'd0, nib} - 8'd10;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/nsr_step.sv =====
// nsr_step: combinational per-byte update of phase, cursor and parity
// depends on nsr_pkg
`timescale 1ns / 1ps
`default_nettype none

module nsr_step #(
    parameter int MAX_BODY = nsr_pkg::MAX_BODY_DEF,
    parameter int CW       = $clog2(MAX_BODY + 1)
) (
    input  wire logic [2:0]      i_phase,
    input  wire logic [CW-1:0]   i_cursor,
    input  wire logic [7:0]      i_parity,
    input  wire logic [7:0]      i_char,
    output      logic [2:0]      o_phase,
    output      logic [CW-1:0]   o_cursor,
    output      logic [7:0]      o_parity,
    output      nsr_pkg::t_result o_res
);

    localparam logic [CW-1:0] LP_MAX = CW'(MAX_BODY);

    logic          stored;
    logic [CW-1:0] cur_base;
    logic [7:0]    par_base;
    logic [CW-1:0] cur_inc;
    logic [CW+6:0] cur_ext;
    logic          is_frame;

    assign is_frame = (i_char == nsr_pkg::CH_CR) || (i_char == nsr_pkg::CH_LF)
                   || (i_char == nsr_pkg::CH_START);

    always_comb begin
        o_phase  = i_phase;
        o_cursor = i_cursor;
        o_parity = i_parity;
        o_res    = '0;
        o_res.event_res = nsr_pkg::EV_NONE;
        stored   = 1'b0;
        cur_base = i_cursor;
        par_base = i_parity;
        cur_ext  = {7'd0, i_cursor};

        unique case (i_phase)
            nsr_pkg::PH_HUNT: begin
                if (i_char == nsr_pkg::CH_START) begin
                    o_phase  = nsr_pkg::PH_START;
                    o_cursor = '0;
                    o_parity = '0;
                end
            end
            nsr_pkg::PH_START: begin
                if (i_char != nsr_pkg::CH_STAR && i_char != nsr_pkg::CH_CR
                    && i_char != nsr_pkg::CH_LF) begin
                    o_phase  = nsr_pkg::PH_BODY;
                    cur_base = '0;
                    par_base = '0;
                    stored   = 1'b1;
                end
            end
            nsr_pkg::PH_BODY: begin
                if (is_frame) begin
                    o_phase  = nsr_pkg::PH_HUNT;
                    o_cursor = '0;
                    o_parity = '0;
                    o_res.event_res = nsr_pkg::EV_ABORT;
                end else if (i_char == nsr_pkg::CH_STAR) begin
                    o_phase = nsr_pkg::PH_CK1;
                end else begin
                    stored = 1'b1;
                end
            end
            nsr_pkg::PH_CK1: begin
                if (i_char == nsr_pkg::hex_digit(i_parity[7:4])) begin
                    o_phase = nsr_pkg::PH_CK2;
                end else begin
                    o_phase  = nsr_pkg::PH_HUNT;
                    o_cursor = '0;
                    o_parity = '0;
                    o_res.event_res = nsr_pkg::EV_ABORT;
                end
            end
            nsr_pkg::PH_CK2: begin
                if (i_char == nsr_pkg::hex_digit(i_parity[3:0])) begin
                    o_phase = nsr_pkg::PH_CR;
                end else begin
                    o_phase  = nsr_pkg::PH_HUNT;
                    o_cursor = '0;
                    o_parity = '0;
                    o_res.event_res = nsr_pkg::EV_ABORT;
                end
            end
            nsr_pkg::PH_CR: begin
                if (i_char == nsr_pkg::CH_CR) begin
                    o_phase = nsr_pkg::PH_LF;
                end else begin
                    o_phase  = nsr_pkg::PH_HUNT;
                    o_cursor = '0;
                    o_parity = '0;
                    o_res.event_res = nsr_pkg::EV_ABORT;
                end
            end
            nsr_pkg::PH_LF: begin
                if (i_char == nsr_pkg::CH_LF) begin
                    o_phase = nsr_pkg::PH_HUNT;
                    o_res.event_res       = nsr_pkg::EV_DONE;
                    o_res.sentence_length = cur_ext[6:0];
                end else begin
                    o_phase  = nsr_pkg::PH_HUNT;
                    o_cursor = '0;
                    o_parity = '0;
                    o_res.event_res = nsr_pkg::EV_ABORT;
                end
            end
            default: begin
                o_phase  = nsr_pkg::PH_HUNT;
                o_cursor = '0;
                o_parity = '0;
            end
        endcase

        cur_inc = cur_base + CW'(1);
        if (stored) begin
            cur_ext = {7'd0, cur_base};
            if (cur_inc >= LP_MAX) begin
                // body full: frame abandoned in place of the byte event
                o_phase  = nsr_pkg::PH_HUNT;
                o_cursor = '0;
                o_parity = '0;
                o_res.event_res = nsr_pkg::EV_ABORT;
            end else begin
                o_cursor = cur_inc;
                o_parity = par_base ^ i_char;
                o_res.event_res  = nsr_pkg::EV_BYTE;
                o_res.body_byte  = i_char;
                o_res.body_index = cur_ext[6:0];
            end
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/nsr_out_reg.sv =====
// nsr_out_reg: result register with valid flag between step logic and output stream
// depends on nsr_pkg
`timescale 1ns / 1ps
`default_nettype none

module nsr_out_reg (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_load,
    input  wire nsr_pkg::t_result i_res,
    input  wire logic             i_m_tready,
    output      logic             o_m_tvalid,
    output      logic             o_free,
    output      nsr_pkg::t_result o_res
);

    logic             r_valid;
    logic             n_valid;
    nsr_pkg::t_result r_res;

    // free when empty or being drained this cycle
    assign o_free  = !r_valid || i_m_tready;
    assign n_valid = i_load || (r_valid && !i_m_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_res      = r_res;

endmodule

`default_nettype wire

// ===== hw/rtl/nmea_sentence_receiver_top.sv =====
// nmea_sentence_receiver_top: byte-serial nmea 0183 sentence framer with xor checksum
// depends on nsr_pkg, nsr_step, nsr_out_reg
// the result of an input transfer is valid on the output register in the next cycle
// throughput: one byte per cycle while the output register is free, set by the combinational phase/cursor/parity update
// a full output register that is not drained stalls input through s_tready
// reset (synchronous, active low) clears phase to hunt, cursor and parity to zero,
// and empties the output register
`timescale 1ns / 1ps
`default_nettype none

module nmea_sentence_receiver_top #(
    parameter int MAX_BODY = nsr_pkg::MAX_BODY_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input stream
    input  wire logic        i_s_tvalid,
    output      logic        o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [7:0] rx_char
    // result stream
    output      logic        o_m_tvalid,
    input  wire logic        i_m_tready,
    output      logic [23:0] o_m_tdata,   // [7:0] body_byte, [14:8] body_index,
                                          // [21:15] sentence_length, [23:22] zero
    output      logic [1:0]  o_m_tuser    // [1:0] event_res
);

    // cursor counts stored body bytes, wide enough to reach MAX_BODY
    localparam int CW = $clog2(MAX_BODY + 1);

    logic [2:0]       r_phase;
    logic [CW-1:0]    r_cursor;
    logic [7:0]       r_parity;
    logic [2:0]       n_phase;
    logic [CW-1:0]    n_cursor;
    logic [7:0]       n_parity;
    nsr_pkg::t_result step_res;
    nsr_pkg::t_result out_res;
    logic             out_free;
    logic             accept;

    // an input transfer happens whenever the output register can take the result
    assign o_s_tready = out_free;
    assign accept     = i_s_tvalid && out_free;

    // per-byte framing logic
    nsr_step #(
        .MAX_BODY (MAX_BODY),
        .CW       (CW)
    ) u_step (
        .i_phase  (r_phase),
        .i_cursor (r_cursor),
        .i_parity (r_parity),
        .i_char   (i_s_tdata),
        .o_phase  (n_phase),
        .o_cursor (n_cursor),
        .o_parity (n_parity),
        .o_res    (step_res)
    );

    // framing state advances only on an input transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= nsr_pkg::PH_HUNT;
            r_cursor <= '0;
            r_parity <= '0;
        end else if (accept) begin
            r_phase  <= n_phase;
            r_cursor <= n_cursor;
            r_parity <= n_parity;
        end
    end

    // result register decouples the two streams
    nsr_out_reg u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (accept),
        .i_res      (step_res),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_free     (out_free),
        .o_res      (out_res)
    );

    assign o_m_tdata = {2'b00, out_res.sentence_length, out_res.body_index,
                        out_res.body_byte};
    assign o_m_tuser = out_res.event_res;

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// tb_top: self-checking bench for nmea_sentence_receiver_top, byte stream in, one result per byte out
// depends on nsr_pkg (codes, framing characters, result layout) and the receiver rtl
`timescale 1ns / 1ps

module tb_top;
    import nsr_pkg::*;

    localparam int BODY_LIMIT = MAX_BODY_DEF;
    localparam int RAND_BYTES = 400;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DIR_ROWS = 26;

    // clock, reset and stream wires
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic [7:0]  s_data = 8'h00;
    logic        s_ready;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [23:0] m_data;
    logic [1:0]  m_user;

    int          cyc_cnt = 0;
    int          errors = 0;
    logic [15:0] stall_pat = 16'hFFFF;

    // one byte to send, with an optional result typed in by hand
    typedef struct {
        logic [7:0] ch;
        bit         pinned;
        t_result    want;
    } rx_item_t;

    // directed rows: byte, pinned, event, body byte, index, length
    typedef struct {
        logic [7:0] ch;
        bit         pinned;
        logic [1:0] ev;
        logic [7:0] b;
        logic [6:0] idx;
        logic [6:0] len;
    } dir_row_t;

    // ways to break a sentence
    typedef enum int {
        F_NONE, F_BODY_CR, F_BODY_DOLLAR, F_CK1, F_CK2, F_LOWER, F_NO_CR, F_NO_LF
    } sent_fault_t;

    dir_row_t dir_tab [DIR_ROWS] = '{
        // junk after reset, then '$' and the flags it eats
        '{8'h00,    1'b1, EV_NONE,  8'h00, 7'd0, 7'd0},
        '{8'hFF,    1'b1, EV_NONE,  8'h00, 7'd0, 7'd0},
        '{CH_START, 1'b1, EV_NONE,  8'h00, 7'd0, 7'd0},
        '{CH_STAR,  1'b1, EV_NONE,  8'h00, 7'd0, 7'd0},
        '{CH_CR,    1'b1, EV_NONE,  8'h00, 7'd0, 7'd0},
        '{CH_LF,    1'b1, EV_NONE,  8'h00, 7'd0, 7'd0},
        // good sentence "AB*03"
        '{8'h41,    1'b1, EV_BYTE,  8'h41, 7'd0, 7'd0},
        '{8'h42,    1'b0, EV_NONE,  8'h00, 7'd0, 7'd0},
        '{CH_STAR,  1'b1, EV_NONE,  8'h00, 7'd0, 7'd0},
        '{8'h30,    1'b1, EV_NONE,  8'h00, 7'd0, 7'd0},
        '{8'h33,    1'b0, EV_NONE,  8'h00, 7'd0, 7'd0},
        '{CH_CR,    1'b1, EV_NONE,  8'h00, 7'd0, 7'd0},
        '{CH_LF,    1'b1, EV_DONE,  8'h00, 7'd0, 7'd2},
        // cr inside the body
        '{CH_START, 1'b1, EV_NONE,  8'h00, 7'd0, 7'd0},
        '{8'h5A,    1'b0, EV_NONE,  8'h00, 7'd0, 7'd0},
        '{CH_CR,    1'b1, EV_ABORT, 8'h00, 7'd0, 7'd0},
        // '$' inside the body aborts and does not restart
        '{CH_START, 1'b1, EV_NONE,  8'h00, 7'd0, 7'd0},
        '{8'h80,    1'b0, EV_NONE,  8'h00, 7'd0, 7'd0},
        '{CH_START, 1'b1, EV_ABORT, 8'h00, 7'd0, 7'd0},
        // lowercase checksum digit
        '{CH_START, 1'b1, EV_NONE,  8'h00, 7'd0, 7'd0},
        '{8'h7F,    1'b0, EV_NONE,  8'h00, 7'd0, 7'd0},
        '{CH_STAR,  1'b0, EV_NONE,  8'h00, 7'd0, 7'd0},
        '{8'h37,    1'b0, EV_NONE,  8'h00, 7'd0, 7'd0},
        '{8'h66,    1'b1, EV_ABORT, 8'h00, 7'd0, 7'd0},
        // top-bit byte opens a body
        '{CH_START, 1'b1, EV_NONE,  8'h00, 7'd0, 7'd0},
        '{8'hFE,    1'b0, EV_NONE,  8'h00, 7'd0, 7'd0}
    };

    rx_item_t rx_stream_q[$];
    t_result  expected_results_q[$];

    // framer state as the predictor sees it
    logic [2:0] frm_phase = PH_HUNT;
    int         body_cnt = 0;
    logic [7:0] xor_acc = 8'h00;

    nmea_sentence_receiver_top #(
        .MAX_BODY   (BODY_LIMIT)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_valid),
        .o_s_tready (s_ready),
        .i_s_tdata  (s_data),
        .o_m_tvalid (m_valid),
        .i_m_tready (m_ready),
        .o_m_tdata  (m_data),
        .o_m_tuser  (m_user)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic [7:0] nib_ascii(input logic [3:0] n);
        return (n < 4'd10) ? 8'h30 + {4'h0, n} : 8'h37 + {4'h0, n};
    endfunction

    function automatic void drop_frame();
        frm_phase = PH_HUNT;
        body_cnt = 0;
        xor_acc = 8'h00;
    endfunction

    // next result of the framer for one received byte
    function automatic t_result predict_frame_step(input logic [7:0] c);
        t_result r;
        bit      keep;
        r = '0;
        keep = 1'b0;
        case (frm_phase)
            PH_HUNT: begin
                if (c == CH_START) begin
                    drop_frame();
                    frm_phase = PH_START;
                end
            end
            PH_START: begin
                if (c != CH_STAR && c != CH_CR && c != CH_LF) begin
                    drop_frame();
                    frm_phase = PH_BODY;
                    keep = 1'b1;
                end
            end
            PH_BODY: begin
                if (c == CH_CR || c == CH_LF || c == CH_START) begin
                    drop_frame();
                    r.event_res = EV_ABORT;
                end else if (c == CH_STAR) begin
                    frm_phase = PH_CK1;
                end else begin
                    keep = 1'b1;
                end
            end
            PH_CK1: begin
                if (c == nib_ascii(xor_acc[7:4])) begin
                    frm_phase = PH_CK2;
                end else begin
                    drop_frame();
                    r.event_res = EV_ABORT;
                end
            end
            PH_CK2: begin
                if (c == nib_ascii(xor_acc[3:0])) begin
                    frm_phase = PH_CR;
                end else begin
                    drop_frame();
                    r.event_res = EV_ABORT;
                end
            end
            PH_CR: begin
                if (c == CH_CR) begin
                    frm_phase = PH_LF;
                end else begin
                    drop_frame();
                    r.event_res = EV_ABORT;
                end
            end
            PH_LF: begin
                // count survives until the next '$'
                if (c == CH_LF) begin
                    r.event_res = EV_DONE;
                    r.sentence_length = body_cnt[6:0];
                    frm_phase = PH_HUNT;
                end else begin
                    drop_frame();
                    r.event_res = EV_ABORT;
                end
            end
            default: begin
                drop_frame();
            end
        endcase
        if (keep) begin
            r.event_res = EV_BYTE;
            r.body_byte = c;
            r.body_index = body_cnt[6:0];
            body_cnt = body_cnt + 1;
            xor_acc = xor_acc ^ c;
            // the byte that fills the body aborts instead of being reported
            if (body_cnt >= BODY_LIMIT) begin
                drop_frame();
                r = '0;
                r.event_res = EV_ABORT;
            end
        end
        return r;
    endfunction

    task automatic queue_byte(input logic [7:0] c);
        rx_item_t it;
        it.ch = c;
        it.pinned = 1'b0;
        it.want = '0;
        rx_stream_q.push_back(it);
    endtask

    // random byte that is no framing character
    function automatic logic [7:0] body_char();
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(0, 255));
        end while (c == CH_CR || c == CH_LF || c == CH_START || c == CH_STAR);
        return c;
    endfunction

    task automatic queue_sentence(input int body_len, input sent_fault_t fault);
        logic [7:0] sum;
        logic [7:0] c;
        logic [7:0] d1;
        logic [7:0] d2;
        int         k;
        int         cut;
        sum = 8'h00;
        queue_byte(CH_START);
        repeat ($urandom_range(0, 2)) begin
            k = $urandom_range(0, 2);
            queue_byte(k == 0 ? CH_STAR : (k == 1 ? CH_CR : CH_LF));
        end
        cut = $urandom_range(0, body_len - 1);
        for (int i = 0; i < body_len; i++) begin
            if (i == cut && fault == F_BODY_CR) begin
                queue_byte($urandom_range(0, 1) ? CH_CR : CH_LF);
                return;
            end
            if (i == cut && fault == F_BODY_DOLLAR) begin
                queue_byte(CH_START);
                return;
            end
            c = body_char();
            sum = sum ^ c;
            queue_byte(c);
        end
        d1 = nib_ascii(sum[7:4]);
        d2 = nib_ascii(sum[3:0]);
        case (fault)
            F_CK1: d1 = d1 ^ 8'h01;
            F_CK2: d2 = d2 ^ 8'h01;
            F_LOWER: begin
                // a digit only turns lowercase where it is a letter
                if (d1 >= 8'h41) d1 = d1 | 8'h20;
                else d2 = d2 | 8'h20;
            end
            default: ;
        endcase
        queue_byte(CH_STAR);
        queue_byte(d1);
        queue_byte(d2);
        queue_byte(fault == F_NO_CR ? body_char() : CH_CR);
        queue_byte(fault == F_NO_LF ? body_char() : CH_LF);
    endtask

    task automatic flag_mismatch(input string what, input int got, input int want);
        $display("cycle %0d: %s mismatch, got %0h want %0h", cyc_cnt, what, got, want);
        errors++;
    endtask

    // receiver stall pattern, changed whenever the low eight bits of the cycle counter are zero, and the run limit
    always @(posedge clk) begin
        cyc_cnt <= cyc_cnt + 1;
        if (cyc_cnt[7:0] == 8'd0) begin
            stall_pat <= ($urandom_range(0, 2) == 0) ? 16'hFFFF
                                                      : (16'($urandom) | 16'h0001);
        end
        m_ready <= stall_pat[cyc_cnt[3:0]];
        if (cyc_cnt >= CYCLE_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // compare each result transfer with the oldest expected result
    always @(posedge clk) begin
        t_result want;
        if (rst_n && m_valid && m_ready) begin
            if (expected_results_q.size() == 0) begin
                flag_mismatch("unexpected result", m_user, 0);
            end else begin
                want = expected_results_q.pop_front();
                if (m_user != want.event_res)
                    flag_mismatch("event_res", m_user, want.event_res);
                if (m_data[7:0] != want.body_byte)
                    flag_mismatch("body_byte", m_data[7:0], want.body_byte);
                if (m_data[14:8] != want.body_index)
                    flag_mismatch("body_index", m_data[14:8], want.body_index);
                if (m_data[21:15] != want.sentence_length)
                    flag_mismatch("sentence_length", m_data[21:15], want.sentence_length);
                if (m_data[23:22] != 2'b00)
                    flag_mismatch("tdata padding", m_data[23:22], 0);
            end
        end
    end

    initial begin
        rx_item_t    it;
        t_result     pred;
        int          burst_left;
        int          len;
        int          rand_base;
        int          pick;
        sent_fault_t fault;

        // directed table first
        for (int k = 0; k < DIR_ROWS; k++) begin
            it.ch = dir_tab[k].ch;
            it.pinned = dir_tab[k].pinned;
            it.want = '0;
            it.want.event_res = dir_tab[k].ev;
            it.want.body_byte = dir_tab[k].b;
            it.want.body_index = dir_tab[k].idx;
            it.want.sentence_length = dir_tab[k].len;
            rx_stream_q.push_back(it);
        end
        // each broken sentence once, then the longest good body and a full body
        for (int f = 1; f <= 7; f++) queue_sentence(3, sent_fault_t'(f));
        queue_sentence(BODY_LIMIT - 1, F_NONE);
        queue_sentence(BODY_LIMIT, F_NONE);

        // random part: mostly sentences, some broken, some line noise
        rand_base = rx_stream_q.size();
        while (rx_stream_q.size() < rand_base + RAND_BYTES) begin
            pick = $urandom_range(0, 99);
            if (pick < 12) begin
                repeat ($urandom_range(1, 6)) queue_byte(8'($urandom_range(0, 255)));
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 4) len = $urandom_range(100, BODY_LIMIT);
                else if (pick < 30) len = $urandom_range(1, 3);
                else len = $urandom_range(4, 24);
                fault = ($urandom_range(0, 99) < 70) ? F_NONE
                                                     : sent_fault_t'($urandom_range(1, 7));
                queue_sentence(len, fault);
            end
        end

        // reset
        drop_frame();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // sender: bursts of transfers separated by idle gaps
        burst_left = $urandom_range(1, 8);
        foreach (rx_stream_q[k]) begin
            it = rx_stream_q[k];
            s_valid <= 1'b1;
            s_data <= it.ch;
            do @(posedge clk); while (!s_ready);
            pred = predict_frame_step(it.ch);
            expected_results_q.push_back(it.pinned ? it.want : pred);
            burst_left--;
            if (burst_left == 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
                burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 160)
                                                          : $urandom_range(1, 8);
            end
        end
        s_valid <= 1'b0;

        // drain, then keep watching for stray results
        while (expected_results_q.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (errors == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
